@@ rtl/core/utli_pkg.sv @@
package utli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FRAC_W      = 16;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] CFG_BASE_ENERGY  = 2'd0;
    localparam logic [1:0] CFG_INVERSE_STEP = 2'd1;
    localparam logic [1:0] CFG_USED_ENTRIES = 2'd2;

    typedef struct packed {
        logic [31:0] base_energy;
        logic [31:0] inverse_step;
        logic [10:0] used_entries;
    } t_cfg;

    // ok: table valid for a query, address in range for a write
    typedef struct packed {
        logic              cmd;
        logic              last;
        logic              ok;
        logic [ADDR_W-1:0] idx;
        logic [FRAC_W:0]   frac;
        logic [31:0]       wr_value;
    } t_pos_item;

    typedef struct packed {
        logic            last;
        logic            ok;
        logic [FRAC_W:0] frac;
        logic [31:0]     v0;
        logic [31:0]     v1;
    } t_blend_item;

endpackage

@@ rtl/core/utli_pos.sv @@
module utli_pos (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  utli_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [31:0]          i_energy,
    input  logic [9:0]           i_entry_index,
    input  logic [31:0]          i_entry_value,
    input  logic                 i_batch_last,
    output logic                 o_valid,
    input  logic                 i_stall,
    output utli_pkg::t_pos_item  o_item
);
    import utli_pkg::*;

    logic              st1, st2, st3;
    logic              r_v1, r_v2, r_v3;
    logic [32:0]       diff;
    logic [31:0]       n_pos;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  nm1;
    logic              cfg_ok;
    logic              n_ok1;
    logic [63:0]       prod;
    t_pos_item         n_item;

    logic              r1_cmd, r1_last, r1_ok;
    logic [31:0]       r1_pos;
    logic [ADDR_W-1:0] r1_addr;
    logic [31:0]       r1_value;

    logic              r2_cmd, r2_last, r2_ok;
    logic [31:0]       r2_ipart;
    logic [FRAC_W-1:0] r2_frac;
    logic [ADDR_W-1:0] r2_addr;
    logic [31:0]       r2_value;

    t_pos_item         r3_item;

    assign st3     = r_v3 && i_stall;
    assign st2     = r_v2 && st3;
    assign st1     = r_v1 && st2;
    assign o_stall = st1;
    assign o_valid = r_v3;
    assign o_item  = r3_item;

    always_comb begin
        if (32'(i_cfg.used_entries) > TABLE_DEPTH) begin
            n_cnt = CNT_W'(TABLE_DEPTH);
        end else begin
            n_cnt = CNT_W'(i_cfg.used_entries);
        end
        nm1    = n_cnt - CNT_W'(1);
        cfg_ok = (n_cnt >= CNT_W'(2)) && (i_cfg.inverse_step != 32'd0);
        diff   = {i_energy[31], i_energy} - {i_cfg.base_energy[31], i_cfg.base_energy};
        if (!diff[32] && (diff[31:0] != 32'd0)) begin
            n_pos = diff[31:0];
        end else begin
            n_pos = 32'd0;
        end
        if (i_cmd == CMD_WRITE) begin
            n_ok1 = 32'(i_entry_index) < TABLE_DEPTH;
        end else begin
            n_ok1 = cfg_ok;
        end
    end

    assign prod = 64'(r1_pos) * 64'(i_cfg.inverse_step);

    always_comb begin
        n_item.cmd      = r2_cmd;
        n_item.last     = r2_last;
        n_item.ok       = r2_ok;
        n_item.wr_value = r2_value;
        if (r2_cmd == CMD_WRITE) begin
            n_item.idx  = r2_addr;
            n_item.frac = '0;
        end else if (r2_ipart >= 32'(nm1)) begin
            n_item.idx  = ADDR_W'(n_cnt - CNT_W'(2));
            n_item.frac = {1'b1, {FRAC_W{1'b0}}};
        end else begin
            n_item.idx  = ADDR_W'(r2_ipart);
            n_item.frac = {1'b0, r2_frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!st1) begin
                r_v1 <= i_valid;
            end
            if (!st2) begin
                r_v2 <= r_v1;
            end
            if (!st3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st1) begin
            r1_cmd   <= i_cmd;
            r1_last  <= i_batch_last;
            r1_ok    <= n_ok1;
            r1_pos   <= n_pos;
            r1_addr  <= ADDR_W'(i_entry_index);
            r1_value <= i_entry_value;
        end
        if (!st2) begin
            r2_cmd   <= r1_cmd;
            r2_last  <= r1_last;
            r2_ok    <= r1_ok;
            r2_ipart <= prod[63:32];
            r2_frac  <= prod[31:32-FRAC_W];
            r2_addr  <= r1_addr;
            r2_value <= r1_value;
        end
        if (!st3) begin
            r3_item <= n_item;
        end
    end

endmodule

@@ rtl/core/utli_table.sv @@
module utli_table (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  utli_pkg::t_pos_item    i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output utli_pkg::t_blend_item  o_item
);
    import utli_pkg::*;

    logic [31:0]       mem [TABLE_DEPTH];
    logic              r_v;
    logic              st;
    logic [ADDR_W-1:0] rd_next;
    logic              r_last, r_ok;
    logic [FRAC_W:0]   r_frac;
    logic [31:0]       r_v0, r_v1;

    assign st      = r_v && i_stall;
    assign o_stall = st;
    assign o_valid = r_v;
    assign rd_next = i_item.idx + ADDR_W'(1);

    assign o_item.last = r_last;
    assign o_item.ok   = r_ok;
    assign o_item.frac = r_frac;
    assign o_item.v0   = r_v0;
    assign o_item.v1   = r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!st) begin
            r_v <= i_valid && (i_item.cmd == CMD_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st) begin
            if (i_valid && (i_item.cmd == CMD_WRITE) && i_item.ok) begin
                mem[i_item.idx] <= i_item.wr_value;
            end
            r_v0   <= mem[i_item.idx];
            r_v1   <= mem[rd_next];
            r_last <= i_item.last;
            r_ok   <= i_item.ok;
            r_frac <= i_item.frac;
        end
    end

endmodule

@@ rtl/core/utli_blend.sv @@
module utli_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  utli_pkg::t_blend_item  i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_interpolated_value,
    output logic                   o_table_ok,
    output logic                   o_result_last
);
    import utli_pkg::*;

    localparam int PROD_W = FRAC_W + 1 + 32;

    logic              st1, st2, st3;
    logic              r_v1, r_v2, r_v3;

    logic              r1_last, r1_ok, r1_up;
    logic [FRAC_W:0]   r1_frac;
    logic [31:0]       r1_v0, r1_delta;

    logic              r2_last, r2_ok, r2_up;
    logic [31:0]       r2_v0;
    logic [PROD_W-1:0] r2_prod;

    logic [PROD_W-1:0] rounded;
    logic [31:0]       step;
    logic [31:0]       n_value;

    logic [31:0]       r3_value;
    logic              r3_ok, r3_last;

    assign st3     = r_v3 && i_stall;
    assign st2     = r_v2 && st3;
    assign st1     = r_v1 && st2;
    assign o_stall = st1;
    assign o_valid = r_v3;

    assign o_interpolated_value = r3_value;
    assign o_table_ok           = r3_ok;
    assign o_result_last        = r3_last;

    // half up in both directions
    always_comb begin
        if (r2_up) begin
            rounded = r2_prod + PROD_W'(32'h8000);
        end else begin
            rounded = r2_prod + PROD_W'(32'h7FFF);
        end
        step = 32'(rounded >> FRAC_W);
        if (!r2_ok) begin
            n_value = 32'd0;
        end else if (r2_up) begin
            n_value = r2_v0 + step;
        end else begin
            n_value = r2_v0 - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!st1) begin
                r_v1 <= i_valid;
            end
            if (!st2) begin
                r_v2 <= r_v1;
            end
            if (!st3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st1) begin
            r1_last <= i_item.last;
            r1_ok   <= i_item.ok;
            r1_frac <= i_item.frac;
            r1_v0   <= i_item.v0;
            r1_up   <= i_item.v1 >= i_item.v0;
            if (i_item.v1 >= i_item.v0) begin
                r1_delta <= i_item.v1 - i_item.v0;
            end else begin
                r1_delta <= i_item.v0 - i_item.v1;
            end
        end
        if (!st2) begin
            r2_last <= r1_last;
            r2_ok   <= r1_ok;
            r2_up   <= r1_up;
            r2_v0   <= r1_v0;
            r2_prod <= PROD_W'(r1_frac) * PROD_W'(r1_delta);
        end
        if (!st3) begin
            r3_value <= n_value;
            r3_ok    <= r2_ok;
            r3_last  <= r2_last;
        end
    end

endmodule

@@ rtl/core/uniform_table_linear_interpolator.sv @@
// Stages from input transfer to result: 3 position, 1 table read, 3 blend.
// Throughput: one item per cycle unless stalled; the 32x32 position multiply, the
// dual-read table stage and the 17x32 blend multiply each sit in a stage of their own.
// Write items end at the table stage and give no result.
// Reset clears stage valids and the configuration registers; the table is not cleared.
module uniform_table_linear_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_energy,
    input  logic [9:0]         i_entry_index,
    input  logic [31:0]        i_entry_value,
    input  logic               i_batch_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_interpolated_value,
    output logic               o_table_ok,
    output logic               o_result_last
);
    import utli_pkg::*;

    t_cfg        r_cfg;
    logic        pos_valid, pos_stall;
    t_pos_item   pos_item;
    logic        tab_valid, tab_stall;
    t_blend_item tab_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BASE_ENERGY:  r_cfg.base_energy  <= i_cfg_data;
                CFG_INVERSE_STEP: r_cfg.inverse_step <= i_cfg_data;
                CFG_USED_ENTRIES: r_cfg.used_entries <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    utli_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_energy      (i_energy),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_batch_last  (i_batch_last),
        .o_valid       (pos_valid),
        .i_stall       (pos_stall),
        .o_item        (pos_item)
    );

    utli_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pos_valid),
        .o_stall (pos_stall),
        .i_item  (pos_item),
        .o_valid (tab_valid),
        .i_stall (tab_stall),
        .o_item  (tab_item)
    );

    utli_blend u_blend (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (tab_valid),
        .o_stall              (tab_stall),
        .i_item               (tab_item),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_interpolated_value (o_interpolated_value),
        .o_table_ok           (o_table_ok),
        .o_result_last        (o_result_last)
    );

`ifndef NO_ASSERTIONS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_table_ok |-> o_interpolated_value == 32'd0)
        else $error("invalid table result not zero");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utli_pkg::*;

    localparam int LATENCY = 7;
    localparam int ITEMS = 1950;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic              cmd;
        logic signed [31:0] energy;
        logic [9:0]        idx;
        logic [31:0]       value;
        logic              last;
    } t_item;

    typedef struct {
        logic [31:0] value;
        logic        ok;
        logic        last;
    } t_interp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_cmd = CMD_QUERY;
    logic signed [31:0] i_energy = '0;
    logic [9:0]         i_entry_index = '0;
    logic [31:0]        i_entry_value = '0;
    logic               i_batch_last = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [31:0]        o_interpolated_value;
    logic               o_table_ok;
    logic               o_result_last;

    uniform_table_linear_interpolator DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_cmd                (i_cmd),
        .i_energy             (i_energy),
        .i_entry_index        (i_entry_index),
        .i_entry_value        (i_entry_value),
        .i_batch_last         (i_batch_last),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_interpolated_value (o_interpolated_value),
        .o_table_ok           (o_table_ok),
        .o_result_last        (o_result_last)
    );

    // mirror of the block's configuration and table
    logic signed [31:0] base_q = '0;
    logic [31:0]        inv_q = '0;
    logic [10:0]        used_q = '0;
    logic [31:0]        value_mem [TABLE_DEPTH];
    bit                 gen_written [TABLE_DEPTH];
    int unsigned        fill_n = 2;

    t_item   item_q [$];
    t_interp interp_q [$];
    t_item   next_item;
    t_interp want;
    int      item_cnt = 0;
    int      mismatches = 0;
    int      gap_left = 0;
    int      hold_left = 0;
    bit      burst = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_interp interpolate(logic signed [31:0] energy, logic last);
        t_interp     r;
        int unsigned n;
        longint      diff;
        logic [63:0] prod;
        logic [9:0]  idx;
        logic [16:0] frac;
        logic [31:0] v0, v1, delta;
        logic [63:0] p;
        r.last = last;
        r.value = '0;
        r.ok = 1'b0;
        n = (used_q > 11'(TABLE_DEPTH)) ? TABLE_DEPTH : 32'(used_q);
        if (n < 2 || inv_q == 0)
            return r;
        diff = longint'(energy) - longint'(base_q);
        prod = (diff > 0) ? 64'(diff) * 64'(inv_q) : 64'd0;
        if (prod[63:32] >= n - 1) begin
            idx = 10'(n - 2);
            frac = 17'h10000;
        end else begin
            idx = 10'(prod[63:32]);
            frac = {1'b0, prod[31:16]};
        end
        v0 = value_mem[idx];
        v1 = value_mem[idx + 10'd1];
        if (v1 >= v0) begin
            delta = v1 - v0;
            p = 64'(frac) * 64'(delta);
            r.value = v0 + 32'((p + 64'h8000) >> 16);
        end else begin
            delta = v0 - v1;
            p = 64'(frac) * 64'(delta);
            r.value = v0 - 32'((p + 64'h7FFF) >> 16);
        end
        r.ok = 1'b1;
        return r;
    endfunction

    // energy spread around the live part of the grid, a little beyond both ends
    function automatic logic [31:0] grid_energy();
        longint      span;
        logic [63:0] r;
        longint      off;
        if (inv_q == 0)
            return $urandom;
        span = (longint'(fill_n) << 32) / longint'(inv_q);
        if (span < 1)
            span = 1;
        r = {$urandom, $urandom};
        off = longint'(r % 64'(span + span / 4 + 1)) - span / 8;
        return 32'(longint'(base_q) + off);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            if (i_cmd == CMD_WRITE)
                value_mem[i_entry_index] = i_entry_value;
            else
                interp_q.push_back(interpolate(i_energy, i_batch_last));
        end
        if (!i_valid || !o_stall) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (item_q.size() != 0) begin
                next_item = item_q.pop_front();
                i_cmd <= next_item.cmd;
                i_energy <= next_item.energy;
                i_entry_index <= next_item.idx;
                i_entry_value <= next_item.value;
                i_batch_last <= next_item.last;
                i_valid <= 1'b1;
                gap_left = burst ? 0 : $urandom_range(0, 7);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (interp_q.size() == 0) begin
                $error("unexpected result: interpolated_value %h", o_interpolated_value);
                mismatches++;
            end else begin
                want = interp_q.pop_front();
                if (o_interpolated_value !== want.value) begin
                    $error("interpolated_value: expected %h, actual %h",
                           want.value, o_interpolated_value);
                    mismatches++;
                end
                if (o_table_ok !== want.ok) begin
                    $error("table_ok: expected %b, actual %b", want.ok, o_table_ok);
                    mismatches++;
                end
                if (o_result_last !== want.last) begin
                    $error("result_last: expected %b, actual %b", want.last, o_result_last);
                    mismatches++;
                end
            end
            hold_left = burst ? 0 : $urandom_range(0, 7);
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
        end
        i_stall <= (hold_left != 0);
    end

    task automatic push_query(logic [31:0] energy, logic last);
        item_q.push_back('{CMD_QUERY, energy, 10'($urandom), $urandom, last});
        item_cnt++;
    endtask

    task automatic push_write(logic [9:0] idx, logic [31:0] value);
        item_q.push_back('{CMD_WRITE, $urandom, idx, value, 1'($urandom)});
        gen_written[idx] = 1'b1;
        item_cnt++;
    endtask

    // wait until nothing is in flight for a full pipeline depth
    task automatic drain();
        int quiet;
        quiet = 0;
        while (quiet < LATENCY + 2) begin
            @(posedge i_clk);
            if (item_q.size() != 0 || i_valid || interp_q.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_BASE_ENERGY:  base_q = data;
            CFG_INVERSE_STEP: inv_q = data;
            CFG_USED_ENTRIES: used_q = data[10:0];
            default: ;
        endcase
    endtask

    // reconfigure while idle, then make sure every entry a query may read is written
    task automatic set_cfg(logic [31:0] base, logic [31:0] inv, logic [10:0] used);
        int unsigned live;
        drain();
        write_reg(CFG_BASE_ENERGY, base);
        write_reg(CFG_INVERSE_STEP, inv);
        write_reg(CFG_USED_ENTRIES, 32'(used));
        i_cfg_we <= 1'b0;
        live = (used > 11'(TABLE_DEPTH)) ? TABLE_DEPTH : 32'(used);
        fill_n = (live < 2) ? 2 : live;
        for (int i = 0; i < fill_n; i++)
            if (!gen_written[10'(i)])
                push_write(10'(i), $urandom);
    endtask

    task automatic query_batch(int count);
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
                push_write(10'($urandom), $urandom);
            else if (sel == 1)
                push_write(10'($urandom_range(0, fill_n - 1)), $urandom);
            else if (sel == 2)
                push_query($urandom, 1'($urandom));
            else
                push_query(grid_energy(), 1'($urandom));
        end
    endtask

    task automatic random_phase();
        logic [31:0] base, inv;
        logic [10:0] used;
        case ($urandom_range(0, 9))
            0:       used = 11'($urandom_range(0, 1));
            1:       used = 11'($urandom_range(17, 64));
            default: used = 11'($urandom_range(2, 16));
        endcase
        case ($urandom_range(0, 7))
            0:       inv = 32'h0;
            1:       inv = $urandom;
            2:       inv = 32'hFFFF_FFFF;
            3:       inv = 32'h0001_0000;
            default: inv = $urandom_range(32'h100, 32'h40_0000);
        endcase
        case ($urandom_range(0, 7))
            0:       base = $urandom;
            1:       base = 32'h8000_0000;
            2:       base = 32'h7FFF_FFFF;
            default: base = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
        burst = ($urandom_range(0, 3) == 0);
        set_cfg(base, inv, used);
        query_batch($urandom_range(20, 60));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: no entries, no step
        push_write(10'd0, 32'h0000_0000);
        push_write(10'd1, 32'hFFFF_FFFF);
        push_write(10'd2, 32'h1234_5678);
        push_write(10'd3, 32'h0001_0000);
        push_query(32'h0000_0000, 1'b1);
        push_query(32'h8000_0000, 1'b0);

        set_cfg(32'h0, 32'h0001_0000, 11'd1);
        push_query(32'h0001_0000, 1'b1);

        set_cfg(32'h0, 32'h0, 11'd4);
        push_query(32'h0001_0000, 1'b0);

        // unit step: ends of the grid, rising and falling segments, clamping
        set_cfg(32'h0, 32'h0001_0000, 11'd4);
        push_query(32'h0000_0000, 1'b0);
        push_query(32'h0000_8000, 1'b1);
        push_query(32'h0001_8000, 1'b0);
        push_query(32'hFFFF_FFFF, 1'b1);
        push_query(32'h7FFF_FFFF, 1'b0);
        push_query(32'h0003_0000, 1'b1);
        push_query(32'h0002_FFFF, 1'b0);
        push_write(10'd3, 32'h0);
        push_query(32'h0002_8000, 1'b1);

        drain();
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;

        set_cfg(32'h8000_0000, 32'hFFFF_FFFF, 11'd4);
        push_query(32'h7FFF_FFFF, 1'b0);
        push_query(32'h8000_0000, 1'b0);
        push_query(32'h8000_0002, 1'b1);

        while (item_cnt < ITEMS - 1150)
            random_phase();

        // full table, then an entry count beyond the table depth
        burst = 1'b0;
        set_cfg($urandom_range(0, 32'h0100_0000), $urandom_range(32'h4000, 32'h2_0000),
                11'(TABLE_DEPTH));
        query_batch(80);
        set_cfg($urandom_range(0, 32'h0100_0000), $urandom_range(32'h4000, 32'h2_0000),
                11'h7FF);
        query_batch(30);

        drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ uniform_table_linear_interpolator.f @@
rtl/core/utli_pkg.sv
rtl/core/utli_pos.sv
rtl/core/utli_table.sv
rtl/core/utli_blend.sv
rtl/core/uniform_table_linear_interpolator.sv
test/tb.sv
